### hdl/bmts_pkg.sv
// shared constants for the battery and thermistor measure sequencer
package bmts_pkg;

   localparam int SAMPLE_W         = 10;
   localparam int BASE_W           = 10;
   localparam int SPAN_W           = 8;
   localparam int MV_W             = 15;
   localparam int TEMP_W           = 16;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 10;

   localparam int CAL_POINTS       = 8;
   localparam int CAL_STEP_DEFAULT = 500;
   localparam int MV_NUMERATOR     = 1126400;
   localparam int MV_NUMERATOR_W   = $clog2(MV_NUMERATOR + 1);
   localparam int MV_SATURATED     = 32767;
   localparam int SMALL_SAMPLE     = 35;
   localparam int TOLERANCE        = 3;
   localparam int TEMP_MAX         = 32767;
   localparam int TEMP_MIN         = -32768;

   localparam int BASE_RESET       = 256;
   localparam int SPAN_RESET       = 64;

   // largest position reached by the segment walk
   localparam int POS_MAX          = (2 ** BASE_W - 1) + (CAL_POINTS - 2) * (2 ** SPAN_W - 1);
   localparam int POS_W            = $clog2(POS_MAX + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_CAL_BASE = CSR_IDX_W'(0);

   localparam logic KIND_START  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

endpackage

### hdl/bmts_if.sv
// request and response channel interfaces
interface bmts_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [bmts_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output kind, output sample, input ready);
   modport sink (input valid, input kind, input sample, output ready);
endinterface

interface bmts_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               keep_running;
   logic                               channel_temp;
   logic                               divider_on;
   logic                               battery_valid;
   logic [bmts_pkg::MV_W-1:0]          battery_mv;
   logic                               temp_valid;
   logic signed [bmts_pkg::TEMP_W-1:0] temperature;

   modport source (output valid, output keep_running, output channel_temp,
                   output divider_on, output battery_valid, output battery_mv,
                   output temp_valid, output temperature, input ready);
   modport sink (input valid, input keep_running, input channel_temp,
                 input divider_on, input battery_valid, input battery_mv,
                 input temp_valid, input temperature, output ready);
endinterface

### hdl/bmts_div.sv
// restoring divider, one quotient bit per cycle
module bmts_div #(
   parameter int DIVIDEND_W = bmts_pkg::MV_NUMERATOR_W,
   parameter int DIVISOR_W  = bmts_pkg::SAMPLE_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_sub;
   logic                  fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      fits      = trial >= {1'b0, dvs_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(DIVIDEND_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = cnt_ff == CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hdl/battery_and_thermistor_measure_sequencer_top.sv
// battery and thermistor measure sequencer, top level
// start and plain sequencing transactions: response registered in the cycle after acceptance
// battery reading: response through the launch, wait and done states, mostly the serial divider
// temperature reading: a segment walk and a multiply step, then the divider
// one transaction in flight; synchronous reset to idle, battery channel, default calibration
module battery_and_thermistor_measure_sequencer_top #(
   parameter int CAL_STEP = bmts_pkg::CAL_STEP_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   bmts_req_if.sink                          req_ch,
   bmts_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [bmts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bmts_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SAMPLE_W = bmts_pkg::SAMPLE_W;
   localparam int POS_W    = bmts_pkg::POS_W;
   localparam int SPAN_W   = bmts_pkg::SPAN_W;
   localparam int PROD_W   = $clog2(bmts_pkg::POS_MAX * CAL_STEP + 1);
   localparam int DIV_W    = (PROD_W > bmts_pkg::MV_NUMERATOR_W) ?
                             PROD_W : bmts_pkg::MV_NUMERATOR_W;
   localparam int SUM_W    = DIV_W + 2;
   localparam int SEG_W    = $clog2(bmts_pkg::CAL_POINTS);
   localparam int LAST_SEG = bmts_pkg::CAL_POINTS - 1;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_DISCARD     = 3'd1,
      PH_BAT_REF     = 3'd2,
      PH_BAT_CHECK   = 3'd3,
      PH_THERM_REF   = 3'd4,
      PH_THERM_CHECK = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MUL,
      ST_LAUNCH,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type                     state_ff, state_in;
   phase_type                     phase_ff, phase_in;
   logic [SAMPLE_W-1:0]           ref_ff, ref_in;
   logic                          chan_ff, chan_in;
   logic [bmts_pkg::BASE_W-1:0]   base_ff, base_in;
   logic [SPAN_W-1:0]             span_ff [1:LAST_SEG];
   logic [SPAN_W-1:0]             span_in [1:LAST_SEG];

   logic [SAMPLE_W-1:0]           smp_ff, smp_in;
   logic                          is_temp_ff, is_temp_in;
   logic                          p_run_ff, p_run_in;
   logic                          p_chan_ff, p_chan_in;
   logic                          p_div_ff, p_div_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [SEG_W-1:0]              seg_ff, seg_in;
   logic                          neg_ff, neg_in;
   logic [DIV_W-1:0]              dvd_ff, dvd_in;
   logic [SAMPLE_W-1:0]           dvs_ff, dvs_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          o_run_ff, o_run_in;
   logic                          o_chan_ff, o_chan_in;
   logic                          o_div_ff, o_div_in;
   logic                          o_bval_ff, o_bval_in;
   logic [bmts_pkg::MV_W-1:0]     o_bmv_ff, o_bmv_in;
   logic                          o_tval_ff, o_tval_in;
   logic signed [bmts_pkg::TEMP_W-1:0] o_temp_ff, o_temp_in;

   logic                          out_free;
   logic                          req_fire;
   logic                          in_tol;
   logic signed [SAMPLE_W:0]      tol_diff;
   logic [SPAN_W-1:0]             span_cur;
   logic [POS_W:0]                seg_end;
   logic signed [POS_W:0]         pos_diff;
   logic [POS_W-1:0]              pos_mag;
   logic signed [SUM_W-1:0]       q_signed;
   logic signed [SUM_W-1:0]       offset;
   logic signed [SUM_W-1:0]       temp_sum;
   logic                          div_start;
   logic                          div_done;
   logic [DIV_W-1:0]              div_quo;

   bmts_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (SAMPLE_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_ff),
      .divisor  (dvs_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign div_start    = state_ff == ST_LAUNCH;

   always_comb begin
      tol_diff = $signed({1'b0, req_ch.sample}) - $signed({1'b0, ref_ff});
      in_tol   = (tol_diff <= $signed((SAMPLE_W + 1)'(bmts_pkg::TOLERANCE))) &&
                 (tol_diff >= -$signed((SAMPLE_W + 1)'(bmts_pkg::TOLERANCE)));
      span_cur = span_ff[seg_ff];
      seg_end  = {1'b0, pos_ff} + (POS_W + 1)'(span_cur);
      pos_diff = $signed((POS_W + 1)'(smp_ff)) - $signed({1'b0, pos_ff});
      pos_mag  = pos_diff[POS_W] ? POS_W'(-pos_diff) : pos_diff[POS_W-1:0];
      q_signed = neg_ff ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
      offset   = SUM_W'((bmts_pkg::CAL_POINTS + 1 - int'(seg_ff)) * CAL_STEP);
      temp_sum = q_signed + offset;
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      ref_in       = ref_ff;
      chan_in      = chan_ff;
      base_in      = base_ff;
      span_in      = span_ff;
      smp_in       = smp_ff;
      is_temp_in   = is_temp_ff;
      p_run_in     = p_run_ff;
      p_chan_in    = p_chan_ff;
      p_div_in     = p_div_ff;
      pos_in       = pos_ff;
      seg_in       = seg_ff;
      neg_in       = neg_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      o_run_in     = o_run_ff;
      o_chan_in    = o_chan_ff;
      o_div_in     = o_div_ff;
      o_bval_in    = o_bval_ff;
      o_bmv_in     = o_bmv_ff;
      o_tval_in    = o_tval_ff;
      o_temp_in    = o_temp_ff;

      if (csr_we) begin
         if (csr_index == bmts_pkg::CSR_CAL_BASE) begin
            base_in = csr_wdata[bmts_pkg::BASE_W-1:0];
         end else begin
            span_in[csr_index] = csr_wdata[SPAN_W-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               p_run_in  = 1'b0;
               p_div_in  = 1'b0;
               smp_in    = req_ch.sample;
               if (req_ch.kind == bmts_pkg::KIND_START) begin
                  phase_in = PH_DISCARD;
                  chan_in  = 1'b0;
                  p_run_in = 1'b1;
               end else begin
                  case (phase_ff)
                     PH_DISCARD: begin
                        phase_in = PH_BAT_REF;
                        p_run_in = 1'b1;
                     end
                     PH_BAT_REF: begin
                        ref_in   = req_ch.sample;
                        phase_in = PH_BAT_CHECK;
                        p_run_in = 1'b1;
                     end
                     PH_BAT_CHECK: begin
                        p_run_in = 1'b1;
                        if (!in_tol) begin
                           ref_in = req_ch.sample;
                        end else begin
                           chan_in    = 1'b1;
                           p_div_in   = 1'b1;
                           phase_in   = PH_THERM_REF;
                           is_temp_in = 1'b0;
                           dvd_in     = DIV_W'(bmts_pkg::MV_NUMERATOR);
                           dvs_in     = req_ch.sample;
                           state_in   = ST_LAUNCH;
                        end
                     end
                     PH_THERM_REF: begin
                        ref_in   = req_ch.sample;
                        phase_in = PH_THERM_CHECK;
                        p_run_in = 1'b1;
                        p_div_in = 1'b1;
                     end
                     PH_THERM_CHECK: begin
                        if (!in_tol) begin
                           ref_in   = req_ch.sample;
                           p_run_in = 1'b1;
                           p_div_in = 1'b1;
                        end else begin
                           phase_in   = PH_IDLE;
                           is_temp_in = 1'b1;
                           pos_in     = POS_W'(base_ff);
                           seg_in     = SEG_W'(1);
                           state_in   = ST_SEARCH;
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
               p_chan_in = chan_in;
               if (state_in == ST_IDLE) begin
                  rsp_valid_in = 1'b1;
                  o_run_in     = p_run_in;
                  o_chan_in    = chan_in;
                  o_div_in     = p_div_in;
                  o_bval_in    = 1'b0;
                  o_bmv_in     = '0;
                  o_tval_in    = 1'b0;
                  o_temp_in    = '0;
               end
            end
         end
         ST_SEARCH: begin
            if (seg_ff == SEG_W'(LAST_SEG) ||
                (POS_W + 1)'(smp_ff) < seg_end) begin
               state_in = ST_MUL;
            end else begin
               pos_in = seg_end[POS_W-1:0];
               seg_in = seg_ff + SEG_W'(1);
            end
         end
         ST_MUL: begin
            neg_in   = !pos_diff[POS_W];
            dvd_in   = DIV_W'(pos_mag * PROD_W'(CAL_STEP));
            dvs_in   = (span_cur == '0) ? SAMPLE_W'(1) : SAMPLE_W'(span_cur);
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_run_in     = p_run_ff;
               o_chan_in    = p_chan_ff;
               o_div_in     = p_div_ff;
               o_bval_in    = !is_temp_ff;
               o_tval_in    = is_temp_ff;
               o_bmv_in     = '0;
               o_temp_in    = '0;
               if (is_temp_ff) begin
                  if (temp_sum > $signed(SUM_W'(bmts_pkg::TEMP_MAX))) begin
                     o_temp_in = bmts_pkg::TEMP_W'(bmts_pkg::TEMP_MAX);
                  end else if (temp_sum < $signed(SUM_W'(bmts_pkg::TEMP_MIN))) begin
                     o_temp_in = bmts_pkg::TEMP_W'(bmts_pkg::TEMP_MIN);
                  end else begin
                     o_temp_in = temp_sum[bmts_pkg::TEMP_W-1:0];
                  end
               end else if (smp_ff < SAMPLE_W'(bmts_pkg::SMALL_SAMPLE)) begin
                  o_bmv_in = bmts_pkg::MV_W'(bmts_pkg::MV_SATURATED);
               end else begin
                  o_bmv_in = div_quo[bmts_pkg::MV_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      smp_ff    <= smp_in;
      is_temp_ff <= is_temp_in;
      p_run_ff  <= p_run_in;
      p_chan_ff <= p_chan_in;
      p_div_ff  <= p_div_in;
      pos_ff    <= pos_in;
      seg_ff    <= seg_in;
      neg_ff    <= neg_in;
      dvd_ff    <= dvd_in;
      dvs_ff    <= dvs_in;
      o_run_ff  <= o_run_in;
      o_chan_ff <= o_chan_in;
      o_div_ff  <= o_div_in;
      o_bval_ff <= o_bval_in;
      o_bmv_ff  <= o_bmv_in;
      o_tval_ff <= o_tval_in;
      o_temp_ff <= o_temp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         ref_ff       <= '0;
         chan_ff      <= 1'b0;
         base_ff      <= bmts_pkg::BASE_W'(bmts_pkg::BASE_RESET);
         for (int i = 1; i <= LAST_SEG; i++) begin
            span_ff[i] <= SPAN_W'(bmts_pkg::SPAN_RESET);
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         ref_ff       <= ref_in;
         chan_ff      <= chan_in;
         base_ff      <= base_in;
         span_ff      <= span_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.keep_running  = o_run_ff;
   assign rsp_ch.channel_temp  = o_chan_ff;
   assign rsp_ch.divider_on    = o_div_ff;
   assign rsp_ch.battery_valid = o_bval_ff;
   assign rsp_ch.battery_mv    = o_bmv_ff;
   assign rsp_ch.temp_valid    = o_tval_ff;
   assign rsp_ch.temperature   = o_temp_ff;

   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ch.ready)
      else $error("input ready while a computation is in flight");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_WAIT))
      else $error("divider finished outside its wait state");

   a_start_responds: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.kind == bmts_pkg::KIND_START) |=>
      (rsp_valid_ff && o_run_ff && !o_chan_ff && !o_div_ff))
      else $error("start transaction did not respond next cycle on battery channel");

   a_one_reading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(o_bval_ff && o_tval_ff))
      else $error("battery and temperature readings in one response");

   a_temp_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_tval_ff) |-> (!o_run_ff && !o_div_ff && phase_ff == PH_IDLE))
      else $error("temperature reading did not end the sequence");

endmodule

### tb/testbench.sv
// testbench for the battery and thermistor measure sequencer: directed table, then random sequences
`timescale 1ns / 1ps

module testbench;

   localparam int SAMPLE_W          = bmts_pkg::SAMPLE_W;
   localparam int BASE_W            = bmts_pkg::BASE_W;
   localparam int SPAN_W            = bmts_pkg::SPAN_W;
   localparam int MV_W              = bmts_pkg::MV_W;
   localparam int TEMP_W            = bmts_pkg::TEMP_W;
   localparam int CSR_IDX_W         = bmts_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W        = bmts_pkg::CSR_DATA_W;
   localparam int CAL_POINTS        = bmts_pkg::CAL_POINTS;
   localparam int MV_NUMERATOR      = bmts_pkg::MV_NUMERATOR;
   localparam int MV_SATURATED      = bmts_pkg::MV_SATURATED;
   localparam int SMALL_SAMPLE      = bmts_pkg::SMALL_SAMPLE;
   localparam int TOLERANCE         = bmts_pkg::TOLERANCE;
   localparam int TEMP_MAX          = bmts_pkg::TEMP_MAX;
   localparam int TEMP_MIN          = bmts_pkg::TEMP_MIN;
   localparam int BASE_RESET        = bmts_pkg::BASE_RESET;
   localparam int SPAN_RESET        = bmts_pkg::SPAN_RESET;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_BASE = bmts_pkg::CSR_CAL_BASE;
   localparam logic KIND_START      = bmts_pkg::KIND_START;
   localparam logic KIND_SAMPLE     = bmts_pkg::KIND_SAMPLE;

   localparam int CAL_STEP          = bmts_pkg::CAL_STEP_DEFAULT;
   localparam int DRAIN_CYCLES      = 40;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int CAL_SETTINGS      = 8;
   localparam int ITEMS_PER_SETTING = 125;
   localparam int REPORT_CAP        = 50;
   localparam int LIMIT_NS          = 12_000_000;

   localparam logic [CSR_IDX_W-1:0] CSR_CAL_STEP_FIRST = CSR_IDX_W'(1);

   typedef enum logic [2:0] {
      PH_IDLE, PH_DISCARD, PH_BAT_REF, PH_BAT_ACCEPT, PH_TEMP_REF, PH_TEMP_ACCEPT
   } seq_phase_type;

   typedef struct packed {
      logic                     keep_running;
      logic                     channel_temp;
      logic                     divider_on;
      logic                     battery_valid;
      logic [MV_W-1:0]          battery_mv;
      logic                     temp_valid;
      logic signed [TEMP_W-1:0] temperature;
   } reading_type;

   typedef struct packed {
      logic                kind;
      logic [SAMPLE_W-1:0] sample;
   } req_item_type;

   typedef struct packed {
      logic                kind;
      logic [SAMPLE_W-1:0] sample;
      logic                typed;
      reading_type         want;
   } meas_row_type;

   localparam reading_type R_NONE       = '0;
   localparam reading_type R_IDLE_BAT   = '{1'b0, 1'b0, 1'b0, 1'b0, 15'd0, 1'b0, 16'sd0};
   localparam reading_type R_IDLE_THERM = '{1'b0, 1'b1, 1'b0, 1'b0, 15'd0, 1'b0, 16'sd0};
   localparam reading_type R_RUN_BAT    = '{1'b1, 1'b0, 1'b0, 1'b0, 15'd0, 1'b0, 16'sd0};
   localparam reading_type R_RUN_THERM  = '{1'b1, 1'b1, 1'b1, 1'b0, 15'd0, 1'b0, 16'sd0};
   localparam reading_type R_BAT_SAT    = '{1'b1, 1'b1, 1'b1, 1'b1, 15'd32767, 1'b0, 16'sd0};

   localparam int DIR_ROWS = 25;
   localparam meas_row_type DIRECTED [DIR_ROWS] = '{
      '{KIND_SAMPLE, 10'd0,    1'b1, R_IDLE_BAT},
      '{KIND_SAMPLE, 10'd1023, 1'b1, R_IDLE_BAT},
      '{KIND_START,  10'd0,    1'b1, R_RUN_BAT},
      '{KIND_SAMPLE, 10'd1023, 1'b1, R_RUN_BAT},
      '{KIND_SAMPLE, 10'd3,    1'b1, R_RUN_BAT},
      '{KIND_SAMPLE, 10'd0,    1'b1, R_BAT_SAT},
      '{KIND_SAMPLE, 10'd1023, 1'b1, R_RUN_THERM},
      '{KIND_SAMPLE, 10'd1019, 1'b1, R_RUN_THERM},
      '{KIND_SAMPLE, 10'd1022, 1'b0, R_NONE},
      '{KIND_SAMPLE, 10'd5,    1'b1, R_IDLE_THERM},
      '{KIND_START,  10'd1023, 1'b1, R_RUN_BAT},
      '{KIND_SAMPLE, 10'd600,  1'b1, R_RUN_BAT},
      '{KIND_START,  10'd0,    1'b1, R_RUN_BAT},
      '{KIND_SAMPLE, 10'd0,    1'b1, R_RUN_BAT},
      '{KIND_SAMPLE, 10'd1023, 1'b1, R_RUN_BAT},
      '{KIND_SAMPLE, 10'd1019, 1'b1, R_RUN_BAT},
      '{KIND_SAMPLE, 10'd1020, 1'b0, R_NONE},
      '{KIND_SAMPLE, 10'd34,   1'b1, R_RUN_THERM},
      '{KIND_START,  10'd512,  1'b1, R_RUN_BAT},
      '{KIND_SAMPLE, 10'd0,    1'b1, R_RUN_BAT},
      '{KIND_SAMPLE, 10'd38,   1'b1, R_RUN_BAT},
      '{KIND_SAMPLE, 10'd35,   1'b0, R_NONE},
      '{KIND_SAMPLE, 10'd0,    1'b1, R_RUN_THERM},
      '{KIND_SAMPLE, 10'd3,    1'b0, R_NONE},
      '{KIND_SAMPLE, 10'd34,   1'b1, R_IDLE_THERM}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bmts_req_if req_bus ();
   bmts_rsp_if rsp_bus ();

   battery_and_thermistor_measure_sequencer_top #(.CAL_STEP(CAL_STEP)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // sequencer state mirrored by the prediction
   seq_phase_type       seq_phase;
   logic [SAMPLE_W-1:0] held_sample;
   logic                therm_selected;
   logic [BASE_W-1:0]   cal_origin;
   logic [SPAN_W-1:0]   cal_width [1:CAL_POINTS-1];

   reading_type pending_readings [$];
   logic        row_typed = 1'b0;
   reading_type row_reading = '0;
   logic        long_hold = 1'b0;

   int req_gap_pct   = 21;
   int rsp_stall_pct = 59;
   int mismatches    = 0;
   int accepted      = 0;
   int responses     = 0;
   int battery_reads = 0;
   int temp_reads    = 0;
   int items_sent    = 0;

   logic [CSR_DATA_W-1:0] cal_plan [CAL_POINTS];

   task automatic report_mismatch(input string what);
      if (mismatches < REPORT_CAP)
         $display("ERROR response %0d: %s", responses, what);
      mismatches++;
   endtask

   function automatic logic [MV_W-1:0] battery_mv_of(input logic [SAMPLE_W-1:0] s);
      if (int'(s) < SMALL_SAMPLE)
         return MV_W'(MV_SATURATED);
      return MV_W'(MV_NUMERATOR / int'(s));
   endfunction

   function automatic logic signed [TEMP_W-1:0] temperature_of(input logic [SAMPLE_W-1:0] s);
      int  pos, seg, span, v, w, smp, k;
      bit  found;
      pos   = int'(cal_origin);
      seg   = CAL_POINTS - 1;
      smp   = int'(s);
      found = 1'b0;
      for (k = 1; k < CAL_POINTS - 1; k++) begin
         w = int'(cal_width[k]);
         if (!found) begin
            if (smp < pos + w) begin
               seg   = k;
               found = 1'b1;
            end else begin
               pos += w;
            end
         end
      end
      span = int'(cal_width[seg]);
      if (span == 0)
         span = 1;
      v = ((smp - pos) * (-CAL_STEP)) / span;
      v += CAL_POINTS * CAL_STEP - (seg - 1) * CAL_STEP;
      if (v < TEMP_MIN)
         v = TEMP_MIN;
      if (v > TEMP_MAX)
         v = TEMP_MAX;
      return TEMP_W'(v);
   endfunction

   function automatic bit near_held(input logic [SAMPLE_W-1:0] s);
      int d;
      d = int'(s) - int'(held_sample);
      return d <= TOLERANCE && d >= -TOLERANCE;
   endfunction

   function automatic reading_type predict_reading(input logic kind,
                                                   input logic [SAMPLE_W-1:0] s);
      reading_type r;
      r = '0;
      if (kind == KIND_START) begin
         seq_phase      = PH_DISCARD;
         therm_selected = 1'b0;
         r.keep_running = 1'b1;
      end else begin
         case (seq_phase)
            PH_DISCARD: begin
               seq_phase      = PH_BAT_REF;
               r.keep_running = 1'b1;
            end
            PH_BAT_REF: begin
               held_sample    = s;
               seq_phase      = PH_BAT_ACCEPT;
               r.keep_running = 1'b1;
            end
            PH_BAT_ACCEPT: begin
               r.keep_running = 1'b1;
               if (!near_held(s)) begin
                  held_sample = s;
               end else begin
                  r.battery_valid = 1'b1;
                  r.battery_mv    = battery_mv_of(s);
                  r.divider_on    = 1'b1;
                  therm_selected  = 1'b1;
                  seq_phase       = PH_TEMP_REF;
               end
            end
            PH_TEMP_REF: begin
               held_sample    = s;
               seq_phase      = PH_TEMP_ACCEPT;
               r.keep_running = 1'b1;
               r.divider_on   = 1'b1;
            end
            PH_TEMP_ACCEPT: begin
               if (!near_held(s)) begin
                  held_sample    = s;
                  r.keep_running = 1'b1;
                  r.divider_on   = 1'b1;
               end else begin
                  r.temp_valid  = 1'b1;
                  r.temperature = temperature_of(s);
                  seq_phase     = PH_IDLE;
               end
            end
            default: seq_phase = PH_IDLE;
         endcase
      end
      r.channel_temp = therm_selected;
      return r;
   endfunction

   task automatic compare_reading(input reading_type got, input reading_type want);
      if (got.keep_running !== want.keep_running)
         report_mismatch($sformatf("keep_running %0b, expected %0b",
                                   got.keep_running, want.keep_running));
      if (got.channel_temp !== want.channel_temp)
         report_mismatch($sformatf("channel_temp %0b, expected %0b",
                                   got.channel_temp, want.channel_temp));
      if (got.divider_on !== want.divider_on)
         report_mismatch($sformatf("divider_on %0b, expected %0b",
                                   got.divider_on, want.divider_on));
      if (got.battery_valid !== want.battery_valid)
         report_mismatch($sformatf("battery_valid %0b, expected %0b",
                                   got.battery_valid, want.battery_valid));
      if (got.battery_mv !== want.battery_mv)
         report_mismatch($sformatf("battery_mv %0d, expected %0d",
                                   got.battery_mv, want.battery_mv));
      if (got.temp_valid !== want.temp_valid)
         report_mismatch($sformatf("temp_valid %0b, expected %0b",
                                   got.temp_valid, want.temp_valid));
      if (got.temperature !== want.temperature)
         report_mismatch($sformatf("temperature %0d, expected %0d",
                                   got.temperature, want.temperature));
   endtask

   always @(posedge clock) begin
      reading_type want;
      reading_type got;
      if (reset) begin
         seq_phase      = PH_IDLE;
         held_sample    = '0;
         therm_selected = 1'b0;
         cal_origin     = BASE_W'(BASE_RESET);
         for (int k = 1; k < CAL_POINTS; k++)
            cal_width[k] = SPAN_W'(SPAN_RESET);
         pending_readings.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CAL_BASE)
               cal_origin = csr_wdata[BASE_W-1:0];
            else
               cal_width[csr_index] = csr_wdata[SPAN_W-1:0];
         end
         if (req_bus.valid && req_bus.ready) begin
            want = predict_reading(req_bus.kind, req_bus.sample);
            if (row_typed)
               want = row_reading;
            pending_readings.push_back(want);
            accepted++;
            battery_reads += int'(want.battery_valid);
            temp_reads    += int'(want.temp_valid);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            responses++;
            got = '{rsp_bus.keep_running, rsp_bus.channel_temp, rsp_bus.divider_on,
                    rsp_bus.battery_valid, rsp_bus.battery_mv, rsp_bus.temp_valid,
                    rsp_bus.temperature};
            if (pending_readings.size() == 0) begin
               report_mismatch("response with no transaction pending");
            end else begin
               want = pending_readings.pop_front();
               compare_reading(got, want);
            end
         end
      end
   end

   // response side: random stalls, and one long hold-off
   initial begin
      int  held;
      bit  hold_done;
      hold_done     = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold && !hold_done) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            for (held = 1; held < LONG_HOLD_CYCLES; held++)
               @(posedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   task automatic offer_req(input logic k, input logic [SAMPLE_W-1:0] s,
                            input logic typed, input reading_type want);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.kind   <= k;
      req_bus.sample <= s;
      row_typed      <= typed;
      row_reading    <= want;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_plain(input logic k, input logic [SAMPLE_W-1:0] s);
      offer_req(k, s, 1'b0, R_NONE);
   endtask

   function automatic logic [SAMPLE_W-1:0] near_sample(input logic [SAMPLE_W-1:0] anchor);
      int s;
      s = int'(anchor) + int'($urandom_range(0, 2 * TOLERANCE)) - TOLERANCE;
      if (s < 0)
         s = 0;
      if (s > 2 ** SAMPLE_W - 1)
         s = 2 ** SAMPLE_W - 1;
      return SAMPLE_W'(s);
   endfunction

   function automatic logic [SAMPLE_W-1:0] away_sample(input logic [SAMPLE_W-1:0] anchor);
      int s;
      do begin
         if ($urandom_range(0, 1) != 0)
            s = int'($urandom_range(0, 2 ** SAMPLE_W - 1));
         else if ($urandom_range(0, 1) != 0)
            s = int'(anchor) + int'($urandom_range(TOLERANCE + 1, 12));
         else
            s = int'(anchor) - int'($urandom_range(TOLERANCE + 1, 12));
      end while (s < 0 || s > 2 ** SAMPLE_W - 1 ||
                 (s - int'(anchor) <= TOLERANCE && s - int'(anchor) >= -TOLERANCE));
      return SAMPLE_W'(s);
   endfunction

   // mostly whole measurement cycles, some cut short, some lone noise transactions
   task automatic random_burst();
      req_item_type        seq [$];
      logic [SAMPLE_W-1:0] anchor;
      int                  roll;
      int                  keep;
      roll = $urandom_range(0, 7);
      if (roll == 0) begin
         send_plain(($urandom_range(0, 1) != 0) ? KIND_SAMPLE : KIND_START,
                    SAMPLE_W'($urandom_range(0, 2 ** SAMPLE_W - 1)));
         return;
      end
      seq.push_back('{KIND_START, SAMPLE_W'($urandom_range(0, 2 ** SAMPLE_W - 1))});
      seq.push_back('{KIND_SAMPLE, SAMPLE_W'($urandom_range(0, 2 ** SAMPLE_W - 1))});
      if ($urandom_range(0, 2) == 0)
         anchor = SAMPLE_W'($urandom_range(0, 40));
      else
         anchor = SAMPLE_W'($urandom_range(0, 2 ** SAMPLE_W - 1));
      seq.push_back('{KIND_SAMPLE, anchor});
      repeat ($urandom_range(0, 2)) begin
         anchor = away_sample(anchor);
         seq.push_back('{KIND_SAMPLE, anchor});
      end
      seq.push_back('{KIND_SAMPLE, near_sample(anchor)});
      anchor = SAMPLE_W'($urandom_range(0, 2 ** SAMPLE_W - 1));
      seq.push_back('{KIND_SAMPLE, anchor});
      repeat ($urandom_range(0, 2)) begin
         anchor = away_sample(anchor);
         seq.push_back('{KIND_SAMPLE, anchor});
      end
      seq.push_back('{KIND_SAMPLE, near_sample(anchor)});
      keep = seq.size();
      if (roll == 1)
         keep = $urandom_range(1, seq.size() - 1);
      for (int i = 0; i < keep; i++)
         send_plain(seq[i].kind, seq[i].sample);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic plan_calibration(input int setting);
      cal_plan[0] = CSR_DATA_W'($urandom_range(0, 2 ** BASE_W - 1));
      for (int k = 1; k < CAL_POINTS; k++)
         cal_plan[k] = CSR_DATA_W'($urandom_range(0, 2 ** CSR_DATA_W - 1));
      case (setting)
         0: begin
            cal_plan[0] = '0;
            for (int k = 1; k < CAL_POINTS; k++) cal_plan[k] = CSR_DATA_W'(1);
         end
         1: begin
            cal_plan[0] = '1;
            for (int k = 1; k < CAL_POINTS; k++) cal_plan[k] = '0;
         end
         3: begin
            cal_plan[0] = '0;
            for (int k = 1; k < CAL_POINTS; k++) cal_plan[k] = '1;
         end
         5: begin
            cal_plan[0] = '1;
            for (int k = 1; k < CAL_POINTS; k++) cal_plan[k] = CSR_DATA_W'(2 ** SPAN_W - 1);
         end
         7: begin
            cal_plan[0] = CSR_DATA_W'(BASE_RESET);
            for (int k = 1; k < CAL_POINTS; k++) cal_plan[k] = CSR_DATA_W'(SPAN_RESET);
         end
         default: ;
      endcase
   endtask

   task automatic write_cal_plan();
      for (int k = 0; k < CAL_POINTS; k++) begin
         csr_we    <= 1'b1;
         csr_index <= (k == 0) ? CSR_CAL_BASE : CSR_CAL_STEP_FIRST + CSR_IDX_W'(k - 1);
         csr_wdata <= cal_plan[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      int phase_start;
      req_bus.valid  = 1'b0;
      req_bus.kind   = KIND_START;
      req_bus.sample = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++)
         offer_req(DIRECTED[i].kind, DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].want);

      for (int p = 0; p < CAL_SETTINGS; p++) begin
         settle();
         if (p == 3) begin
            req_gap_pct   = 59;
            rsp_stall_pct = 21;
         end
         if (p == 6) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end
         plan_calibration(p);
         write_cal_plan();
         if (p == 6)
            long_hold <= 1'b1;
         phase_start = items_sent;
         while (items_sent - phase_start < ITEMS_PER_SETTING)
            random_burst();
      end
      settle();

      $display("covered %0d transactions under %0d calibration settings plus reset values",
               accepted, CAL_SETTINGS);
      $display("%0d battery and %0d temperature readings checked, %0d mismatches",
               battery_reads, temp_reads, mismatches);
      if (mismatches == 0)
         $display("PASS battery_and_thermistor_measure_sequencer_top");
      else
         $display("FAIL battery_and_thermistor_measure_sequencer_top");
      $finish;
   end

   initial begin
      #(LIMIT_NS * 1ns);
      $display("timeout with %0d responses outstanding", pending_readings.size());
      $display("FAIL battery_and_thermistor_measure_sequencer_top");
      $finish;
   end

endmodule
